// File: hw/rtl/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg - shared types and constants
// Geometry, kernel codes, register indexes and the job record passed from the
// front end to the filter back end.
// ----------------------------------------------------------------------------
package rcf_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WEFF_W      = COL_W + 1;
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int HEFF_W      = ROW_W + 1;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int WIN_N       = 9;

  localparam int OUT_COL_W   = 11;
  localparam int OUT_ROW_W   = 12;
  localparam int OUT_TDATA_W = 48;

  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 13;

  localparam int FIFO_DEPTH  = 4;
  localparam int LEVEL_W     = $clog2(FIFO_DEPTH + 1);

  // floor(s / 9) == (s * DIV9_RECIP) >> DIV9_SHIFT for every box sum
  localparam int SUM_W       = 12;
  localparam int DIV9_RECIP  = 7282;
  localparam int DIV9_SHIFT  = 16;
  localparam int RECIP_W     = 13;
  localparam int ACC_W       = 12;

  localparam logic [1:0] MODE_BOX     = 2'd0;
  localparam logic [1:0] MODE_EDGE    = 2'd1;
  localparam logic [1:0] MODE_SHARPEN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef pixel_t win_t [WIN_N];

  typedef struct packed {
    pixel_t [WIN_N-1:0]     win;
    logic [OUT_COL_W-1:0]   col;
    logic [OUT_ROW_W-1:0]   row;
    logic                   last;
  } job_t;

endpackage

// File: hw/rtl/rcf_ram.sv
// ----------------------------------------------------------------------------
// rcf_ram - simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/rcf_front.sv
// ----------------------------------------------------------------------------
// rcf_front - raster tracking, line stores and 3x3 window
// Counts position, reads and updates both line stores, slides the window and
// queues one job for each interior centre pixel.
// ----------------------------------------------------------------------------
module rcf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pix_accept,
  input  rcf_pkg::pixel_t               pix,
  input  logic [rcf_pkg::WIDTH_W-1:0]   cfg_width,
  input  logic [rcf_pkg::HEIGHT_W-1:0]  cfg_height,
  output logic                          job_push,
  output rcf_pkg::job_t                 job
);
  import rcf_pkg::*;

  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  row_nxt;
  logic [WEFF_W-1:0] w_eff;
  logic [HEFF_W-1:0] h_eff;
  logic [WEFF_W-1:0] x_ext;
  logic [HEFF_W-1:0] y_ext;
  logic              last_col;
  logic              emit;

  logic              f1_valid_r;
  logic              f1_emit_r;
  logic              f1_last_r;
  pixel_t            f1_px_r;
  logic [COL_W-1:0]  f1_addr_r;
  logic [OUT_COL_W-1:0] f1_col_r;
  logic [OUT_ROW_W-1:0] f1_row_r;

  win_t              win_r;
  win_t              win_nxt;
  pixel_t            up1;
  pixel_t            up2;

  always_comb begin
    if (cfg_width < WIDTH_W'(3)) begin
      w_eff = WEFF_W'(3);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(cfg_width);
    end
    if (cfg_height < HEIGHT_W'(3)) begin
      h_eff = HEFF_W'(3);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(cfg_height);
    end
  end

  assign x_ext    = WEFF_W'(col_r);
  assign y_ext    = HEFF_W'(row_r);
  assign last_col = (x_ext + WEFF_W'(1)) >= w_eff;
  assign emit     = (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2)) &&
                    (x_ext < w_eff) && (y_ext < h_eff);

  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = ((y_ext + HEFF_W'(1)) >= h_eff) ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= pix_accept;
      if (pix_accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      f1_px_r   <= pix;
      f1_addr_r <= col_r;
      f1_emit_r <= emit;
      f1_last_r <= (x_ext == w_eff - WEFF_W'(1)) && (y_ext == h_eff - HEFF_W'(1));
      f1_col_r  <= OUT_COL_W'(col_r - COL_W'(1));
      f1_row_r  <= OUT_ROW_W'(row_r - ROW_W'(1));
    end
  end

  // store a: previous row, store b: the row before
  rcf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk     (clk),
    .wr_en   (f1_valid_r),
    .wr_addr (f1_addr_r),
    .wr_data (f1_px_r),
    .rd_en   (pix_accept),
    .rd_addr (col_r),
    .rd_data (up1)
  );

  rcf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk     (clk),
    .wr_en   (f1_valid_r),
    .wr_addr (f1_addr_r),
    .wr_data (up1),
    .rd_en   (pix_accept),
    .rd_addr (col_r),
    .rd_data (up2)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3+0] = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = up2;
    win_nxt[5] = up1;
    win_nxt[8] = f1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_N; i++) begin
        win_r[i] <= '0;
      end
    end else if (f1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  assign job_push = f1_valid_r && f1_emit_r;

  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      job.win[i] = win_nxt[i];
    end
    job.col  = f1_col_r;
    job.row  = f1_row_r;
    job.last = f1_last_r;
  end

endmodule

// File: hw/rtl/rcf_fifo.sv
// ----------------------------------------------------------------------------
// rcf_fifo - job queue
// Short register FIFO between window front end and filter back end.
// ----------------------------------------------------------------------------
module rcf_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  rcf_pkg::job_t                push_data,
  input  logic                         pop,
  output logic                         pop_valid,
  output rcf_pkg::job_t                pop_data,
  output logic [rcf_pkg::LEVEL_W-1:0]  level
);
  import rcf_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  job_t               mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [LEVEL_W-1:0] level_r;
  logic               do_pop;

  assign do_pop    = pop && (level_r != '0);
  assign pop_valid = (level_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign level     = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !do_pop) begin
        level_r <= level_r + LEVEL_W'(1);
      end else if (!push && do_pop) begin
        level_r <= level_r - LEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LEVEL_W'(FIFO_DEPTH))
    else $error("job queue level beyond depth");

  a_ptr_level: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r == '0 || level_r == LEVEL_W'(FIFO_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("job queue pointers disagree with level");

endmodule

// File: hw/rtl/rcf_back.sv
// ----------------------------------------------------------------------------
// rcf_back - kernel datapath
// Two-stage filter: window sums and kernel terms, then divide by nine or
// clamp, into the result register.
// ----------------------------------------------------------------------------
module rcf_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [1:0]                      mode,
  input  logic                            job_valid,
  input  rcf_pkg::job_t                   job,
  output logic                            job_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rcf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import rcf_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;

  logic                     s1_valid_r;
  logic                     s1_box_r;
  logic [SUM_W-1:0]         s1_sum_r [3];
  logic signed [ACC_W-1:0]  s1_acc_r [3];
  logic [OUT_COL_W-1:0]     s1_col_r;
  logic [OUT_ROW_W-1:0]     s1_row_r;
  logic                     s1_last_r;
  logic                     s1_ready;
  logic                     s2_ready;

  logic [SUM_W-1:0]         sum_nxt [3];
  logic signed [ACC_W-1:0]  acc_nxt [3];
  logic [CH_W-1:0]          ch_nxt [3];

  logic                     out_valid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;
  logic                     out_last_r;

  function automatic logic [SUM_W-1:0] chan(input pixel_t p, input int k);
    return SUM_W'(p[k*CH_W +: CH_W]);
  endfunction

  assign s2_ready = !out_valid_r || out_tready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign job_pop  = job_valid && s1_ready;

  always_comb begin
    logic [SUM_W-1:0] c;
    logic [SUM_W-1:0] nbr;
    logic signed [ACC_W:0] t;
    for (int k = 0; k < 3; k++) begin
      c   = chan(job.win[4], k);
      nbr = chan(job.win[1], k) + chan(job.win[3], k) +
            chan(job.win[5], k) + chan(job.win[7], k);
      sum_nxt[k] = nbr + c + chan(job.win[0], k) + chan(job.win[2], k) +
                   chan(job.win[6], k) + chan(job.win[8], k);
      if (mode == MODE_EDGE) begin
        t = $signed({1'b0, SUM_W'(c * SUM_W'(9))}) - $signed({1'b0, sum_nxt[k]});
      end else begin
        t = $signed({1'b0, SUM_W'(c * SUM_W'(5))}) - $signed({1'b0, nbr});
      end
      acc_nxt[k] = ACC_W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      s1_box_r  <= !(mode == MODE_EDGE || mode == MODE_SHARPEN);
      s1_sum_r  <= sum_nxt;
      s1_acc_r  <= acc_nxt;
      s1_col_r  <= job.col;
      s1_row_r  <= job.row;
      s1_last_r <= job.last;
    end
  end

  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int k = 0; k < 3; k++) begin
      prod = PROD_W'(s1_sum_r[k]) * PROD_W'(DIV9_RECIP);
      if (s1_box_r) begin
        ch_nxt[k] = CH_W'(prod >> DIV9_SHIFT);
      end else if (s1_acc_r[k] < 0) begin
        ch_nxt[k] = '0;
      end else if (s1_acc_r[k] > ACC_W'(255)) begin
        ch_nxt[k] = '1;
      end else begin
        ch_nxt[k] = CH_W'(s1_acc_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_data_r <= {1'b0, s1_row_r, s1_col_r, ch_nxt[2], ch_nxt[1], ch_nxt[0]};
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> s1_valid_r)
    else $error("kernel stage dropped a job under stall");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |-> !job_pop)
    else $error("job taken while kernel stage stalled");

endmodule

// File: hw/rtl/rgb_conv3x3_filter_unit.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_filter_unit - 3x3 RGB convolution filter
// Box blur, edge detect or sharpen over a raster pixel stream; one result
// per interior pixel.
//
//   port group  dir  fields (lsb first)
//   in_         in   tdata: red_in, green_in, blue_in
//   out_        out  tdata: red_out, green_out, blue_out, out_col, out_row;
//                    tlast: frame_last
//   cfg_        in   index 0 filter_mode, 1 image_width, 2 image_height
//
// One pixel per clock while in_tready is high; a result passes the front register, the job queue,
// the kernel stage and the result register. The line-store read, window update and queue push form the one-per-cycle
// front loop; the kernel back end is a two-stage pipeline.
// in_tready falls while the job queue holds more than two jobs.
// No clearing pass after reset: unwritten line-store entries reach only windows that queue no job.
// Reset is synchronous, active low; cfg_ready is always high.
// ----------------------------------------------------------------------------
module rgb_conv3x3_filter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rcf_pkg::PIX_W-1:0]         in_tdata,   // red_in, green_in, blue_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rcf_pkg::OUT_TDATA_W-1:0]   out_tdata,  // red, green, blue, col, row
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rcf_pkg::*;

  logic [1:0]          mode_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;

  logic                pix_accept;
  logic                job_push;
  job_t                job_in;
  logic                job_pop;
  logic                job_valid;
  job_t                job_out;
  logic [LEVEL_W-1:0]  level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BOX;
      width_r  <= WIDTH_W'(2048);
      height_r <= HEIGHT_W'(4096);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode_r   <= cfg_data[1:0];
        REG_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready  = (level <= LEVEL_W'(FIFO_DEPTH - 2));
  assign pix_accept = in_tvalid && in_tready;

  rcf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_accept (pix_accept),
    .pix        (in_tdata),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .job_push   (job_push),
    .job        (job_in)
  );

  rcf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .pop_valid (job_valid),
    .pop_data  (job_out),
    .level     (level)
  );

  rcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .job_valid  (job_valid),
    .job        (job_out),
    .job_pop    (job_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (level != LEVEL_W'(FIFO_DEPTH)))
    else $error("job pushed into full queue");

  a_push_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> $past(pix_accept))
    else $error("job pushed without a pixel transfer");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    pix_accept |-> (level <= LEVEL_W'(FIFO_DEPTH - 2)))
    else $error("pixel transfer without queue credit");

endmodule
